>>> rtl/ptbl_pkg.sv
`default_nettype none
package ptbl_pkg;

    localparam int TableDepthDef = 1024;
    localparam int BatchLenDef   = 64;
    localparam int TokenBitsDef  = 16;

    localparam int IN_W       = 144;
    localparam int OUT_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int BUCKET_W   = 10;

    localparam logic [15:0] LIMIT_RESET  = 16'd16;
    localparam logic [15:0] REFILL_RESET = 16'd1;

    // Rounds per item: two per message block, two for the length block, four to finish.
    localparam int HASH_ROUNDS_V4 = 8;
    localparam int HASH_ROUNDS_V6 = 10;

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

    typedef enum logic [2:0] {
        ACT_CHECK_V4  = 3'd0,
        ACT_CHECK_V6  = 3'd1,
        ACT_RETURN_V4 = 3'd2,
        ACT_RETURN_V6 = 3'd3,
        ACT_TICK      = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        REG_KEY_LOW     = 2'd0,
        REG_KEY_HIGH    = 2'd1,
        REG_TOKEN_LIMIT = 2'd2,
        REG_REFILL      = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MSG_W0  = 2'd0,
        MSG_W1  = 2'd1,
        MSG_LEN = 2'd2
    } msg_sel_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MSTART,
        ST_MOD,
        ST_READ,
        ST_UPDATE,
        ST_TICK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load;
        logic     hash_round;
        logic     xor_in;
        logic     xor_out;
        logic     xor_ff;
        msg_sel_t msg_sel;
        logic     mod_start;
        logic     rd_bucket;
        logic     tick_rd;
        logic     wr_en;
        logic     clear_wr;
        logic     commit;
    } ptbl_cmd_t;

    typedef struct packed {
        logic mod_done;
        logic out_free;
        logic is_v6;
    } ptbl_status_t;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } sip_state_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic sip_state_t sip_round(input sip_state_t s);
        sip_state_t t;
        t = s;
        t.v0 = t.v0 + t.v1;
        t.v1 = rotl64(t.v1, 13) ^ t.v0;
        t.v0 = rotl64(t.v0, 32);
        t.v2 = t.v2 + t.v3;
        t.v3 = rotl64(t.v3, 16) ^ t.v2;
        t.v0 = t.v0 + t.v3;
        t.v3 = rotl64(t.v3, 21) ^ t.v0;
        t.v2 = t.v2 + t.v1;
        t.v1 = rotl64(t.v1, 17) ^ t.v2;
        t.v2 = rotl64(t.v2, 32);
        return t;
    endfunction

    function automatic logic [63:0] bswap64(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ptbl_ram.sv
`default_nettype none
module ptbl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/ptbl_ctrl.sv
`default_nettype none
module ptbl_ctrl #(
    parameter int TABLE_DEPTH = ptbl_pkg::TableDepthDef,
    parameter int BATCH_LEN   = ptbl_pkg::BatchLenDef
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic [2:0]                      in_action,
    output logic                                 in_ready,
    input  wire ptbl_pkg::ptbl_status_t          status,
    output ptbl_pkg::ptbl_cmd_t                  cmd,
    output logic [$clog2(TABLE_DEPTH):0]         step
);
    import ptbl_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH) + 1;
    localparam int SIZE  = (BATCH_LEN > TABLE_DEPTH || BATCH_LEN == 0) ?
                           TABLE_DEPTH : BATCH_LEN;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]       k;
    logic [3:0]       blk_rounds;
    logic [2:0]       n_blocks;
    logic [CNT_W-1:0] hash_last;

    assign k          = cnt_reg[3:0];
    assign blk_rounds = status.is_v6 ? 4'd6 : 4'd4;
    assign n_blocks   = status.is_v6 ? 3'd2 : 3'd1;
    assign hash_last  = status.is_v6 ? CNT_W'(HASH_ROUNDS_V6 - 1) :
                                       CNT_W'(HASH_ROUNDS_V4 - 1);
    assign step       = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.msg_sel = MSG_W0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (cnt_reg == CNT_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (in_action inside {ACT_CHECK_V4, ACT_CHECK_V6,
                                          ACT_RETURN_V4, ACT_RETURN_V6})
                    begin
                        state_next = ST_HASH;
                    end
                    else if (in_action == ACT_TICK)
                    begin
                        state_next = ST_TICK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_HASH:
            begin
                cmd.hash_round = 1'b1;
                cmd.xor_in     = (k < blk_rounds) && !k[0];
                cmd.xor_out    = (k < blk_rounds) && k[0];
                cmd.xor_ff     = (k == blk_rounds);
                if (k[3:1] < n_blocks)
                begin
                    cmd.msg_sel = (k[3:1] == 3'd0) ? MSG_W0 : MSG_W1;
                end
                else
                begin
                    cmd.msg_sel = MSG_LEN;
                end
                if (cnt_reg == hash_last)
                begin
                    state_next = ST_MSTART;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MSTART:
            begin
                cmd.mod_start = 1'b1;
                state_next    = ST_MOD;
            end
            ST_MOD:
            begin
                if (status.mod_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_bucket = 1'b1;
                state_next    = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                // Reads run one entry ahead of the writes.
                cmd.tick_rd = (cnt_reg < CNT_W'(SIZE));
                cmd.wr_en   = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(SIZE))
                begin
                    state_next = ST_DONE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/ptbl_dp.sv
`default_nettype none
module ptbl_dp #(
    parameter int TABLE_DEPTH = ptbl_pkg::TableDepthDef,
    parameter int BATCH_LEN   = ptbl_pkg::BatchLenDef,
    parameter int TOKEN_BITS  = ptbl_pkg::TokenBitsDef
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [ptbl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [ptbl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic [ptbl_pkg::IN_W-1:0]           in_data,
    input  wire ptbl_pkg::ptbl_cmd_t                 cmd,
    input  wire logic [$clog2(TABLE_DEPTH):0]        step,
    output ptbl_pkg::ptbl_status_t                   status,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [ptbl_pkg::OUT_W-1:0]               out_data
);
    import ptbl_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int SIZE      = (BATCH_LEN > TABLE_DEPTH || BATCH_LEN == 0) ?
                               TABLE_DEPTH : BATCH_LEN;
    localparam int NUM_BATCH = TABLE_DEPTH / SIZE;
    localparam int PTR_W     = (NUM_BATCH > 1) ? $clog2(NUM_BATCH) : 1;
    localparam int SUM_W     = ((TOKEN_BITS > 16) ? TOKEN_BITS : 16) + 1;
    localparam bit IS_POW2   = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [16:0] DEP = 17'(TABLE_DEPTH);
    localparam logic [31:0] FILL32 = 32'(LIMIT_RESET);
    localparam logic [TOKEN_BITS-1:0] FILL = FILL32[TOKEN_BITS-1:0];

    // Configuration registers.
    logic [63:0] key_low_reg, key_high_reg;
    logic [15:0] limit_reg, refill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            limit_reg    <= LIMIT_RESET;
            refill_reg   <= REFILL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_KEY_LOW:     key_low_reg  <= cfg_wdata;
                REG_KEY_HIGH:    key_high_reg <= cfg_wdata;
                REG_TOKEN_LIMIT: limit_reg    <= cfg_wdata[15:0];
                REG_REFILL:      refill_reg   <= cfg_wdata[15:0];
                default:         ;
            endcase
        end
    end

    // Input fields and prefix masking.
    logic [2:0]   in_action;
    logic [63:0]  in_upper, in_lower;
    logic [7:0]   in_plen;
    logic [5:0]   v4_bits;
    logic [7:0]   v6_bits;
    logic [31:0]  mask32;
    logic [127:0] mask128;
    logic [63:0]  m0_load, m1_load;

    assign in_action = in_data[2:0];
    assign in_upper  = in_data[66:3];
    assign in_lower  = in_data[130:67];
    assign in_plen   = in_data[138:131];
    assign v4_bits   = (in_plen > 8'd32) ? 6'd32 : in_plen[5:0];
    assign v6_bits   = (in_plen > 8'd128) ? 8'd128 : in_plen;
    assign mask32    = (v4_bits == 6'd0) ? 32'd0 : ~32'd0 << (6'd32 - v4_bits);
    assign mask128   = (v6_bits == 8'd0) ? 128'd0 : ~128'd0 << (8'd128 - v6_bits);

    always_comb
    begin
        if (in_action == ACT_CHECK_V6 || in_action == ACT_RETURN_V6)
        begin
            m0_load = bswap64(in_upper & mask128[127:64]);
        end
        else
        begin
            m0_load = {32'd0, in_lower[31:0] & mask32};
        end
        m1_load = bswap64(in_lower & mask128[63:0]);
    end

    // SipHash state, one round a cycle.
    sip_state_t  v_reg, v_next, v_pre, v_post;
    logic [63:0] m0_reg, m1_reg;
    logic [2:0]  act_reg;
    logic        v6_reg;
    logic [63:0] msg;

    always_comb
    begin
        case (cmd.msg_sel)
            MSG_W0:  msg = m0_reg;
            MSG_W1:  msg = m1_reg;
            MSG_LEN: msg = v6_reg ? (64'd16 << 56) : (64'd8 << 56);
            default: msg = '0;
        endcase
        v_pre = v_reg;
        if (cmd.xor_in)
        begin
            v_pre.v3 = v_pre.v3 ^ msg;
        end
        if (cmd.xor_ff)
        begin
            v_pre.v2 = v_pre.v2 ^ 64'hff;
        end
        v_post = sip_round(v_pre);
        if (cmd.xor_out)
        begin
            v_post.v0 = v_post.v0 ^ msg;
        end
        v_next = v_reg;
        if (cmd.load)
        begin
            v_next.v0 = key_low_reg ^ SIP_C0;
            v_next.v1 = key_high_reg ^ SIP_C1;
            v_next.v2 = key_low_reg ^ SIP_C2;
            v_next.v3 = key_high_reg ^ SIP_C3;
        end
        else if (cmd.hash_round)
        begin
            v_next = v_post;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        if (cmd.load)
        begin
            m0_reg  <= m0_load;
            m1_reg  <= m1_load;
            act_reg <= in_action;
            v6_reg  <= (in_action == ACT_CHECK_V6 || in_action == ACT_RETURN_V6);
        end
    end

    // Hash reduced to a bucket index: the low hash bits for a power-of-two depth, else eight hash bits a cycle.
    logic [63:0] hash;
    logic [63:0] hash_sr_reg;
    logic [16:0] rem_reg, rem_step;
    logic [3:0]  mod_cnt_reg;
    logic [IDX_W-1:0] bucket_idx;

    assign hash = v_reg.v0 ^ v_reg.v1 ^ v_reg.v2 ^ v_reg.v3;

    always_comb
    begin
        rem_step = rem_reg;
        for (int i = 0; i < 8; i++)
        begin
            rem_step = {rem_step[15:0], hash_sr_reg[63-i]};
            if (rem_step >= DEP)
            begin
                rem_step = rem_step - DEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_cnt_reg <= '0;
        end
        else if (cmd.mod_start)
        begin
            mod_cnt_reg <= IS_POW2 ? 4'd0 : 4'd8;
        end
        else if (mod_cnt_reg != 4'd0)
        begin
            mod_cnt_reg <= mod_cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mod_start)
        begin
            hash_sr_reg <= hash;
            rem_reg     <= IS_POW2 ? 17'(hash[IDX_W-1:0]) : 17'd0;
        end
        else if (mod_cnt_reg != 4'd0)
        begin
            hash_sr_reg <= hash_sr_reg << 8;
            rem_reg     <= rem_step;
        end
    end

    assign bucket_idx = rem_reg[IDX_W-1:0];

    // Batch pointer for refill ticks.
    logic [PTR_W-1:0] ptr_reg;
    logic [IDX_W:0]   start_full;
    logic [IDX_W-1:0] start;

    assign start_full = (IDX_W+1)'(ptr_reg) * (IDX_W+1)'(SIZE);
    assign start      = start_full[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.commit && act_reg == ACT_TICK)
        begin
            ptr_reg <= (ptr_reg == PTR_W'(NUM_BATCH - 1)) ? '0 : ptr_reg + 1'b1;
        end
    end

    // Token table.
    logic                  ram_re, ram_we;
    logic [IDX_W-1:0]      raddr, waddr, raddr_prev_reg;
    logic [TOKEN_BITS-1:0] rdata, wdata, lim;
    logic [31:0]           lim32;
    logic [SUM_W-1:0]      refill_sum;

    assign lim32      = {16'd0, limit_reg};
    assign lim        = lim32[TOKEN_BITS-1:0];
    assign ram_re     = cmd.rd_bucket || cmd.tick_rd;
    assign ram_we     = cmd.wr_en || cmd.clear_wr;
    assign raddr      = cmd.rd_bucket ? bucket_idx : start + step[IDX_W-1:0];
    assign waddr      = cmd.clear_wr ? step[IDX_W-1:0] : raddr_prev_reg;
    assign refill_sum = SUM_W'(rdata) + SUM_W'(refill_reg);

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            raddr_prev_reg <= raddr;
        end
    end

    always_comb
    begin
        if (cmd.clear_wr)
        begin
            wdata = FILL;
        end
        else if (act_reg == ACT_TICK)
        begin
            wdata = (refill_sum >= SUM_W'(lim)) ? lim : refill_sum[TOKEN_BITS-1:0];
        end
        else if (act_reg == ACT_CHECK_V4 || act_reg == ACT_CHECK_V6)
        begin
            wdata = (rdata != '0) ? rdata - 1'b1 : rdata;
        end
        else
        begin
            wdata = (rdata < lim) ? rdata + 1'b1 : rdata;
        end
    end

    ptbl_ram #(
        .WIDTH (TOKEN_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Result register.
    logic        out_valid_reg, permitted_reg;
    logic [9:0]  bucket_reg;
    logic [31:0] bucket32;
    logic        is_check, is_hashed;

    assign is_check  = (act_reg == ACT_CHECK_V4 || act_reg == ACT_CHECK_V6);
    assign is_hashed = is_check || act_reg == ACT_RETURN_V4 || act_reg == ACT_RETURN_V6;
    assign bucket32  = is_hashed ? 32'(bucket_idx) :
                       (act_reg == ACT_TICK) ? 32'(start) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            permitted_reg <= is_check && (rdata != '0);
            bucket_reg    <= bucket32[BUCKET_W-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = {5'd0, bucket_reg, permitted_reg};
    assign status.mod_done = (mod_cnt_reg == 4'd0);
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.is_v6    = v6_reg;

endmodule
`default_nettype wire

>>> rtl/per_prefix_token_bucket_limiter_core.sv
// Check or return: key load, one SipHash round a cycle (more rounds for IPv6), reduction
// of the hash to a bucket index, bucket read, update; a depth that is not a power of two adds a serial reduction.
// Refill tick: one table entry of the batch read and written a cycle.
// Another item is accepted in the cycle after the result is registered.
// Reset is asynchronous, active low; afterwards a clearing pass fills the table
// while no item is accepted.
`default_nettype none
module per_prefix_token_bucket_limiter_core #(
    parameter int TABLE_DEPTH = ptbl_pkg::TableDepthDef,
    parameter int BATCH_LEN   = ptbl_pkg::BatchLenDef,
    parameter int TOKEN_BITS  = ptbl_pkg::TokenBitsDef
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [ptbl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [ptbl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // action[2:0], addr_upper[66:3], addr_lower[130:67], prefix_len[138:131]
    input  wire logic [ptbl_pkg::IN_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // permitted[0], bucket[10:1]
    output logic [ptbl_pkg::OUT_W-1:0]            m_tdata
);
    import ptbl_pkg::*;

    ptbl_cmd_t                  cmd;
    ptbl_status_t               status;
    logic [$clog2(TABLE_DEPTH):0] step;

    ptbl_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .BATCH_LEN   (BATCH_LEN)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (s_tdata[2:0]),
        .in_ready  (s_tready),
        .status    (status),
        .cmd       (cmd),
        .step      (step)
    );

    ptbl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .BATCH_LEN   (BATCH_LEN),
        .TOKEN_BITS  (TOKEN_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .step      (step),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // A result is only registered when the output stage is free.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("result registered over one not yet taken");

    // One item at a time: an accepted transaction makes the input busy.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready straight after a transaction");

    // Load, hash-round, bucket-read, tick-read and clear commands never overlap.
    a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.hash_round, cmd.rd_bucket, cmd.tick_rd, cmd.clear_wr}))
        else $error("overlapping datapath commands");

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import ptbl_pkg::*;

    localparam int DEPTH = 1024;
    localparam int BATCH = 64;
    localparam int NBATCH = DEPTH / BATCH;

    typedef struct packed {
        logic        permitted;
        logic [9:0]  bucket;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // Shadow copy of the limiter state.
    logic [63:0] key_lo, key_hi;
    logic [15:0] limit_q, refill_q;
    logic [15:0] tokens [DEPTH];
    int unsigned next_batch;

    verdict_t pending_verdicts[$];
    int errors = 0;
    int out_wait = 0;
    bit sending = 1'b0;

    per_prefix_token_bucket_limiter_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] rol(logic [63:0] x, int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic void mix(ref logic [63:0] v [4]);
        v[0] = v[0] + v[1]; v[1] = rol(v[1], 13) ^ v[0]; v[0] = rol(v[0], 32);
        v[2] = v[2] + v[3]; v[3] = rol(v[3], 16) ^ v[2];
        v[0] = v[0] + v[3]; v[3] = rol(v[3], 21) ^ v[0];
        v[2] = v[2] + v[1]; v[1] = rol(v[1], 17) ^ v[2]; v[2] = rol(v[2], 32);
    endfunction

    function automatic logic [63:0] keyed_hash(logic [63:0] w0, logic [63:0] w1, int n);
        logic [63:0] v [4];
        logic [63:0] m;
        v[0] = key_lo ^ 64'h736f6d6570736575;
        v[1] = key_hi ^ 64'h646f72616e646f6d;
        v[2] = key_lo ^ 64'h6c7967656e657261;
        v[3] = key_hi ^ 64'h7465646279746573;
        for (int i = 0; i <= n; i++)
        begin
            m = (i == n) ? (64'(n * 8) << 56) : (i == 0 ? w0 : w1);
            v[3] ^= m;
            mix(v);
            mix(v);
            v[0] ^= m;
        end
        v[2] ^= 64'hff;
        for (int i = 0; i < 4; i++)
        begin
            mix(v);
        end
        return v[0] ^ v[1] ^ v[2] ^ v[3];
    endfunction

    function automatic logic [63:0] leading_ones(int k);
        if (k <= 0)
            return 64'd0;
        if (k >= 64)
            return '1;
        return ~64'd0 << (64 - k);
    endfunction

    function automatic logic [63:0] swap_bytes(logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction

    function automatic int bucket_of(action_t act, logic [63:0] up, logic [63:0] lo,
                                     int plen);
        logic [63:0] h;
        logic [63:0] lm;
        logic [31:0] net;
        if (act == ACT_CHECK_V4 || act == ACT_RETURN_V4)
        begin
            if (plen > 32)
                plen = 32;
            lm = leading_ones(plen);
            net = lo[31:0] & lm[63:32];
            h = keyed_hash({32'd0, net}, 64'd0, 1);
        end
        else
        begin
            up &= leading_ones(plen > 64 ? 64 : plen);
            lo &= leading_ones(plen > 64 ? plen - 64 : 0);
            h = keyed_hash(swap_bytes(up), swap_bytes(lo), 2);
        end
        return int'(h % DEPTH);
    endfunction

    function automatic verdict_t predict_limiter(logic [2:0] act, logic [63:0] up,
                                                 logic [63:0] lo, logic [7:0] plen);
        verdict_t r;
        int b;
        logic [16:0] t;
        r = '0;
        if (act <= ACT_RETURN_V6)
        begin
            b = bucket_of(action_t'(act), up, lo, plen);
            r.bucket = 10'(b);
            if (act <= ACT_CHECK_V6)
            begin
                if (tokens[b] != 0)
                begin
                    tokens[b]--;
                    r.permitted = 1'b1;
                end
            end
            else if (tokens[b] < limit_q)
                tokens[b]++;
        end
        else if (act == ACT_TICK)
        begin
            r.bucket = 10'(next_batch * BATCH);
            for (int i = 0; i < BATCH; i++)
            begin
                t = tokens[next_batch*BATCH + i] + refill_q;
                tokens[next_batch*BATCH + i] = (t >= limit_q) ? limit_q : t[15:0];
            end
            next_batch = (next_batch + 1) % NBATCH;
        end
        return r;
    endfunction

    // The valid line is left high after a transaction; the next call either
    // replaces the data at once or drops valid for its idle cycles.
    task automatic send_item(logic [2:0] act, logic [63:0] up, logic [63:0] lo,
                             logic [7:0] plen);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pending_verdicts.push_back(predict_limiter(act, up, lo, plen));
        s_tdata <= {5'd0, plen, lo, up, act};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        cfg_addr <= idx;
        cfg_wdata <= val;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_KEY_LOW:     key_lo = val;
            REG_KEY_HIGH:    key_hi = val;
            REG_TOKEN_LIMIT: limit_q = val[15:0];
            default:         refill_q = val[15:0];
        endcase
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Addresses from a small pool so buckets get emptied and refilled.
    logic [63:0] pool_up [8], pool_lo [8];

    task automatic random_item;
        int k, sel;
        logic [2:0] act;
        logic [63:0] up, lo;
        k = $urandom_range(0, 7);
        up = pool_up[k];
        lo = pool_lo[k];
        if ($urandom_range(0, 3) == 0)
        begin
            up = rand64();
            lo = rand64();
        end
        sel = $urandom_range(0, 19);
        act = 3'(sel < 9 ? ACT_CHECK_V4 + (sel & 1) : sel < 16 ? ACT_RETURN_V4 + (sel & 1)
            : sel < 19 ? ACT_TICK : $urandom_range(5, 7));
        send_item(act, up, lo, 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                              : $urandom_range(0, 128)));
    endtask

    task automatic test_directed;
        send_item(ACT_CHECK_V4, '1, '1, 8'd32);
        send_item(ACT_CHECK_V4, '1, '1, 8'd0);
        send_item(ACT_CHECK_V4, '0, 64'h0000_0000_c0a8_0101, 8'd255);
        send_item(ACT_CHECK_V6, '1, '1, 8'd128);
        send_item(ACT_CHECK_V6, '1, '1, 8'd0);
        send_item(ACT_CHECK_V6, 64'h2001_0db8_0000_0001, '1, 8'd64);
        send_item(ACT_CHECK_V6, 64'h2001_0db8_0000_0001, '1, 8'd200);
        send_item(ACT_RETURN_V4, '1, '1, 8'd32);
        send_item(ACT_RETURN_V6, '1, '1, 8'd128);
        send_item(3'd5, '1, '1, 8'd7);
        send_item(3'd6, '0, '0, 8'd0);
        send_item(3'd7, '1, '0, 8'd255);
        for (int i = 0; i < 18; i++)
            send_item(ACT_CHECK_V4, '0, 64'h0a00_0001, 8'd8);
        for (int i = 0; i <= NBATCH; i++)
            send_item(ACT_TICK, '0, '0, 8'd0);
        drain();
    endtask

    task automatic test_config_limits;
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_TOKEN_LIMIT, 64'd0);
        write_reg(REG_REFILL, 64'hffff);
        for (int i = 0; i < 60; i++)
            random_item();
        drain();
        // Raising the limit with no refill; lowering it later leaves counters above it until they drain or refill.
        write_reg(REG_TOKEN_LIMIT, 64'hffff);
        write_reg(REG_REFILL, 64'd0);
        for (int i = 0; i < 80; i++)
            random_item();
        drain();
        write_reg(REG_TOKEN_LIMIT, 64'd3);
        write_reg(REG_REFILL, 64'd2);
        for (int i = 0; i < 80; i++)
            random_item();
        drain();
    endtask

    task automatic test_random;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_KEY_LOW, rand64());
            write_reg(REG_KEY_HIGH, rand64());
            write_reg(REG_TOKEN_LIMIT, 64'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                                     : $urandom_range(1, 6)));
            write_reg(REG_REFILL, 64'($urandom_range(0, 3)));
            for (int i = 0; i < 8; i++)
            begin
                pool_up[i] = rand64();
                pool_lo[i] = rand64();
            end
            for (int i = 0; i < 200; i++)
                random_item();
            drain();
        end
    endtask

    // After each taken result a random wait is drawn that holds off the next valid one; no wait once sending stops.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected transaction: %h", m_tdata);
            end
            else
            begin
                verdict_t exp;
                exp = pending_verdicts.pop_front();
                if (m_tdata[0] !== exp.permitted || m_tdata[10:1] !== exp.bucket)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected permitted %0d bucket %0d, got %0d %0d",
                                 exp.permitted, exp.bucket, m_tdata[0], m_tdata[10:1]);
                end
            end
            out_wait = $urandom_range(0, 3);
        end
        else if (m_tvalid && out_wait != 0)
        begin
            out_wait--;
        end
        m_tready <= (out_wait == 0) || !sending;
    end

    initial
    begin
        key_lo = '0;
        key_hi = '0;
        limit_q = LIMIT_RESET;
        refill_q = REFILL_RESET;
        next_batch = 0;
        for (int i = 0; i < DEPTH; i++)
            tokens[i] = LIMIT_RESET;
        for (int i = 0; i < 8; i++)
        begin
            pool_up[i] = rand64();
            pool_lo[i] = rand64();
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sending = 1'b1;
        test_directed();
        test_config_limits();
        test_random();
        sending = 1'b0;
        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
rtl/ptbl_pkg.sv
rtl/ptbl_ram.sv
rtl/ptbl_ctrl.sv
rtl/ptbl_dp.sv
rtl/per_prefix_token_bucket_limiter_core.sv
verif/tb_top.sv
